// ===== src/fsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_pkg
// Shared types, constants and byte classifiers for the file name stream
// validator.
// ----------------------------------------------------------------------------
package fsv_pkg;

    localparam int MAX_INPUT = 65535;
    localparam int COUNT_W   = $clog2(MAX_INPUT + 2);
    localparam int OFFSET_W  = 16;
    localparam int CLEN_W    = 9;
    localparam int CLEN_MAX  = 256;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_EMPTY     = 3'd1;
    localparam logic [2:0] STATUS_TOO_LONG  = 3'd2;
    localparam logic [2:0] STATUS_TRAILING  = 3'd3;
    localparam logic [2:0] STATUS_DOTS      = 3'd4;
    localparam logic [2:0] STATUS_CONTROL   = 3'd5;
    localparam logic [2:0] STATUS_BAD_CHAR  = 3'd6;
    localparam logic [2:0] STATUS_DASH      = 3'd7;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    typedef struct packed {
        logic                control_seen;
        logic [COUNT_W-1:0]  byte_count;
        logic [OFFSET_W-1:0] component_start;
        logic [CLEN_W-1:0]   component_length;
        logic [7:0]          first_byte;
        logic                only_dots;
        logic                bad_char;
    } str_state_t;

    localparam str_state_t STR_CLEAR = '{
        control_seen:     1'b0,
        byte_count:       '0,
        component_start:  '0,
        component_length: '0,
        first_byte:       8'h00,
        only_dots:        1'b1,
        bad_char:         1'b0
    };

    function automatic logic is_control(input logic [7:0] b);
        return (b < CHAR_SPACE) || (b == CHAR_DEL);
    endfunction

    function automatic logic allowed_byte(input logic [7:0] b);
        logic lower;
        logic upper;
        logic digit;
        lower = (b >= 8'h61) && (b <= 8'h7A);
        upper = (b >= 8'h41) && (b <= 8'h5A);
        digit = (b >= 8'h30) && (b <= 8'h39);
        return lower || upper || digit || (b == CHAR_DOT) || (b == CHAR_DASH) ||
               (b == CHAR_UNDER) || (b == CHAR_PLUS) || (b == CHAR_AT) ||
               (b == CHAR_EQ);
    endfunction

endpackage

// ===== src/filename_stream_validator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filename_stream_validator_top
// Checks a path string, one byte per word, and reports whether its final
// component is a safe file name, with that component's offset and length.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one byte per word with has_byte and end_of_name flags. Only
//   the end word of a string produces a result word on m_*; status is the
//   rejection code, name_offset/name_length locate the basename (zero when
//   rejected).
//   cfg_* writes max_name_length; cfg_ready is always high. Write it only
//   while no string is in flight.
// Timing:
//   one word per cycle sustained, while no end word is held back by a result
//   waiting on m_ready. A word is captured in the input register, then the
//   state update and verdict feed the result register, which drives m_*.
// Reset:
//   synchronous active-low aresetn empties both registers, clears the string
//   state and sets max_name_length to 255.
// Stall:
//   while a result waits on m_ready, ordinary bytes keep flowing in; an end
//   word holds in the input register and s_ready drops until the result is
//   taken.
// ----------------------------------------------------------------------------
module filename_stream_validator_top
    import fsv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_byte,
    input  logic                s_has_byte,
    input  logic                s_end_of_name,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [OFFSET_W-1:0] m_name_offset,
    output logic [7:0]          m_name_length,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_has_reg;
    logic                in_end_reg;
    logic [7:0]          max_len_reg;

    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [7:0]          out_length_reg;

    logic                out_free;
    logic                advance;
    str_state_t          str_next;
    logic [2:0]          judge_status;
    logic [OFFSET_W-1:0] judge_offset;
    logic [7:0]          judge_length;

    assign out_free = !out_valid_reg || m_ready;
    // only an end word needs room in the result register
    assign advance  = in_valid_reg && (!in_end_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_char_byte;
            in_has_reg  <= s_has_byte;
            in_end_reg  <= s_end_of_name;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= 8'hFF;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    fsv_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .char_byte   (in_byte_reg),
        .has_byte    (in_has_reg),
        .end_of_name (in_end_reg),
        .str_next    (str_next)
    );

    fsv_judge u_judge (
        .str_state       (str_next),
        .max_name_length (max_len_reg),
        .status          (judge_status),
        .name_offset     (judge_offset),
        .name_length     (judge_length)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_end_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_end_reg) begin
            out_status_reg <= judge_status;
            out_offset_reg <= judge_offset;
            out_length_reg <= judge_length;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_name_offset = out_offset_reg;
    assign m_name_length = out_length_reg;

endmodule

// ===== src/fsv_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_tracker
// Holds the per-string state and folds in one byte per advance; clears the
// state after the end word of a string.
// ----------------------------------------------------------------------------
module fsv_tracker
    import fsv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] char_byte,
    input  logic       has_byte,
    input  logic       end_of_name,
    output str_state_t str_next
);

    str_state_t state_reg;

    always_comb begin
        str_next = state_reg;
        if (has_byte) begin
            if (is_control(char_byte)) begin
                str_next.control_seen = 1'b1;
            end
            if (char_byte == CHAR_SLASH) begin
                str_next.component_start  = OFFSET_W'(state_reg.byte_count + COUNT_W'(1));
                str_next.component_length = '0;
                str_next.first_byte       = 8'h00;
                str_next.only_dots        = 1'b1;
                str_next.bad_char         = 1'b0;
            end else begin
                if (state_reg.component_length == '0) begin
                    str_next.first_byte = char_byte;
                end
                if (state_reg.component_length < CLEN_W'(CLEN_MAX)) begin
                    str_next.component_length = state_reg.component_length + CLEN_W'(1);
                end
                if (char_byte != CHAR_DOT) begin
                    str_next.only_dots = 1'b0;
                end
                if (!allowed_byte(char_byte)) begin
                    str_next.bad_char = 1'b1;
                end
            end
            // saturates one past the limit so an overlong string stays marked
            if (state_reg.byte_count <= COUNT_W'(MAX_INPUT)) begin
                str_next.byte_count = state_reg.byte_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STR_CLEAR;
        end else if (advance) begin
            state_reg <= end_of_name ? STR_CLEAR : str_next;
        end
    end

endmodule

// ===== src/fsv_judge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_judge
// Turns the final string state into a status code and the basename window.
// ----------------------------------------------------------------------------
module fsv_judge
    import fsv_pkg::*;
(
    input  str_state_t          str_state,
    input  logic [7:0]          max_name_length,
    output logic [2:0]          status,
    output logic [OFFSET_W-1:0] name_offset,
    output logic [7:0]          name_length
);

    always_comb begin
        // checks in priority order
        if (str_state.byte_count == '0) begin
            status = STATUS_EMPTY;
        end else if (str_state.byte_count > COUNT_W'(MAX_INPUT)) begin
            status = STATUS_TOO_LONG;
        end else if (str_state.control_seen) begin
            status = STATUS_CONTROL;
        end else if (str_state.component_length == '0) begin
            status = STATUS_TRAILING;
        end else if (str_state.only_dots && (str_state.component_length <= CLEN_W'(2))) begin
            status = STATUS_DOTS;
        end else if (str_state.component_length > CLEN_W'(max_name_length)) begin
            status = STATUS_TOO_LONG;
        end else if (str_state.first_byte == CHAR_DASH) begin
            status = STATUS_DASH;
        end else if (str_state.bad_char) begin
            status = STATUS_BAD_CHAR;
        end else begin
            status = STATUS_OK;
        end
    end

    assign name_offset = (status == STATUS_OK) ? str_state.component_start : '0;
    assign name_length = (status == STATUS_OK) ? str_state.component_length[7:0] : 8'h00;

endmodule

// ===== tb/filename_stream_validator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filename_stream_validator_top_test
// Drives path strings through the validator a byte per word and checks each
// verdict word against a cycle-free model of the string scanner. A directed
// table covers the rejection codes, limit extremes and long names; random
// paths follow under several name length limits with random idling on both
// channels.
// ----------------------------------------------------------------------------
module filename_stream_validator_top_test;
    import fsv_pkg::*;

    localparam int       PATH_WORDS = 950;
    localparam int       LIMIT_NS   = 12_000_000;
    localparam int       SETTLE_CYC = 4;
    localparam logic [7:0] FILL_BYTE = 8'h78;  // 'x'
    localparam string    NAME_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-_+@=";

    typedef struct packed {
        logic [7:0] b;
        logic       hb;
        logic       eon;
    } word_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          length;
    } verdict_t;

    typedef struct {
        int    cfg;       // limit written ahead of the row, -1 keeps it
        string txt;
        int    pad;       // fill bytes sent ahead of txt
        int    tail;      // raw byte after txt, -1 for none
        bit    bare_end;  // close with a word that carries no byte
        bit    noise;     // ignored word after the first one
        bit    typed;
        int    status;
        int    offset;
        int    length;
    } plan_row_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [7:0]          s_char_byte   = 8'h00;
    logic                s_has_byte    = 1'b0;
    logic                s_end_of_name = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [2:0]          m_status;
    logic [OFFSET_W-1:0] m_name_offset;
    logic [7:0]          m_name_length;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_data      = 8'h00;

    // scanner model state
    logic [7:0]          name_limit  = 8'd255;
    logic                path_ctrl   = 1'b0;
    logic [COUNT_W-1:0]  path_count  = '0;
    logic [OFFSET_W-1:0] name_start  = '0;
    logic [CLEN_W-1:0]   name_len    = '0;
    logic [7:0]          name_first  = 8'h00;
    logic                name_dots   = 1'b1;
    logic                name_bad    = 1'b0;

    verdict_t            pending_verdicts[$];
    word_t               path_q[$];
    plan_row_t           plan[$];
    int                  fail_count  = 0;
    int                  path_items  = 0;
    bit                  quiet       = 1'b0;

    always #2 aclk = ~aclk;

    filename_stream_validator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_byte   (s_char_byte),
        .s_has_byte    (s_has_byte),
        .s_end_of_name (s_end_of_name),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_name_offset (m_name_offset),
        .m_name_length (m_name_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    function automatic bit name_char_ok(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return 1'b1;
        if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A) return 1'b1;
        case (b)
            CHAR_DOT, CHAR_DASH, CHAR_UNDER, CHAR_PLUS, CHAR_AT, CHAR_EQ: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_path();
        path_ctrl  = 1'b0;
        path_count = '0;
        name_start = '0;
        name_len   = '0;
        name_first = 8'h00;
        name_dots  = 1'b1;
        name_bad   = 1'b0;
    endfunction

    // appends one word to the path being built
    function automatic void add_word(input word_t w);
        path_q.insert(path_q.size(), w);
    endfunction

    // advances the scanner by one word, returns 1 when the word closes a path
    function automatic bit scan_path_word(input word_t w, output verdict_t v);
        logic [2:0] st;
        v = '0;
        if (w.hb) begin
            if (w.b < CHAR_SPACE || w.b == CHAR_DEL) path_ctrl = 1'b1;
            if (w.b == CHAR_SLASH) begin
                name_start = path_count[OFFSET_W-1:0] + 1'b1;
                name_len   = '0;
                name_first = 8'h00;
                name_dots  = 1'b1;
                name_bad   = 1'b0;
            end else begin
                if (name_len == 0) name_first = w.b;
                if (name_len < CLEN_MAX) name_len = name_len + 1'b1;
                if (w.b != CHAR_DOT) name_dots = 1'b0;
                if (!name_char_ok(w.b)) name_bad = 1'b1;
            end
            if (path_count <= MAX_INPUT) path_count = path_count + 1'b1;
        end
        if (!w.eon) return 1'b0;

        if (path_count == 0)                     st = STATUS_EMPTY;
        else if (path_count > MAX_INPUT)         st = STATUS_TOO_LONG;
        else if (path_ctrl)                      st = STATUS_CONTROL;
        else if (name_len == 0)                  st = STATUS_TRAILING;
        else if (name_dots && name_len <= 2)     st = STATUS_DOTS;
        else if (name_len > {1'b0, name_limit})  st = STATUS_TOO_LONG;
        else if (name_first == CHAR_DASH)        st = STATUS_DASH;
        else if (name_bad)                       st = STATUS_BAD_CHAR;
        else                                     st = STATUS_OK;
        v.status = st;
        if (st == STATUS_OK) begin
            v.offset = name_start;
            v.length = name_len[7:0];
        end
        clear_path();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic note_mismatch(input string msg);
        if (fail_count < 60) $display("ERROR %0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic send_word(input word_t w, input bit use_row, input verdict_t row_v);
        verdict_t got;
        int       gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_byte   <= w.b;
        s_has_byte    <= w.hb;
        s_end_of_name <= w.eon;
        do @(posedge aclk); while (!s_ready);
        if (w.hb || w.eon) path_items++;
        if (scan_path_word(w, got))
            pending_verdicts.insert(pending_verdicts.size(), use_row ? row_v : got);
    endtask

    task automatic send_path(input bit use_row, input verdict_t row_v);
        for (int i = 0; i < path_q.size(); i++)
            send_word(path_q[i], use_row && (i == path_q.size() - 1), row_v);
    endtask

    // stop sending and let every verdict in flight drain
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        name_limit = v;
    endtask

    task automatic add_component(input bit last);
        int style;
        int len;
        int odd_pos;
        logic [7:0] odd;
        style   = $urandom_range(0, 59);
        len     = (style == 0) ? $urandom_range(250, 262) : $urandom_range(1, 8);
        odd_pos = $urandom_range(0, len - 1);
        if (style >= 13 && style <= 14) odd = (style == 13) ? 8'h7F : 8'($urandom_range(0, 31));
        else begin
            odd = 8'($urandom_range(0, 255));
            if (odd == CHAR_SLASH) odd = 8'hAF;
        end
        if (style >= 1 && style <= 4) begin
            // dot-only names, one to three dots
            repeat ($urandom_range(1, 3)) add_word('{CHAR_DOT, 1'b1, 1'b0});
        end else begin
            for (int i = 0; i < len; i++) begin
                if (i == 0 && style >= 5 && style <= 7)
                    add_word('{CHAR_DASH, 1'b1, 1'b0});
                else if (i == odd_pos && style >= 8 && style <= 14)
                    add_word('{odd, 1'b1, 1'b0});
                else
                    add_word('{NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)],
                               1'b1, 1'b0});
            end
        end
        if (!last) add_word('{CHAR_SLASH, 1'b1, 1'b0});
    endtask

    task automatic build_random_path();
        int kind;
        int comps;
        kind = $urandom_range(0, 19);
        path_q.delete();
        if (kind == 1) begin
            repeat ($urandom_range(1, 12))
                add_word('{8'($urandom_range(0, 255)), 1'b1, 1'b0});
        end else if (kind != 0) begin
            if ($urandom_range(0, 3) == 0) add_word('{CHAR_SLASH, 1'b1, 1'b0});
            comps = $urandom_range(1, 3);
            for (int c = 0; c < comps; c++) add_component(c == comps - 1);
            if ($urandom_range(0, 7) == 0) add_word('{CHAR_SLASH, 1'b1, 1'b0});
        end
        // words without a byte in mid-string are ignored by the block
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                path_q.insert($urandom_range(0, path_q.size()),
                              '{8'($urandom_range(0, 255)), 1'b0, 1'b0});
        if (path_q.size() == 0 || $urandom_range(0, 4) == 0)
            add_word('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
        else
            path_q[path_q.size() - 1].eon = 1'b1;
    endtask

    // result channel: random stalls, compare against the oldest verdict
    initial begin : result_sink
        int       stall;
        verdict_t want;
        wait (aresetn == 1'b1);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_verdicts.size() == 0) begin
                note_mismatch($sformatf("result word with nothing pending: status %0d",
                                        m_status));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_status !== want.status)
                    note_mismatch($sformatf("status got %0d expected %0d",
                                            m_status, want.status));
                if (m_name_offset !== want.offset)
                    note_mismatch($sformatf("name_offset got %0d expected %0d",
                                            m_name_offset, want.offset));
                if (m_name_length !== want.length)
                    note_mismatch($sformatf("name_length got %0d expected %0d",
                                            m_name_length, want.length));
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        verdict_t row_v;
        int       paths;
        int       lim;

        plan = '{
            '{-1, "",          0, -1, 1, 0, 1, STATUS_EMPTY,    0, 0},
            '{-1, "a",         0, -1, 0, 0, 1, STATUS_OK,       0, 1},
            '{-1, "",        255, -1, 0, 0, 1, STATUS_OK,       0, 255},
            '{-1, "",        256, -1, 0, 0, 1, STATUS_TOO_LONG, 0, 0},
            '{-1, "",        520, -1, 0, 0, 1, STATUS_TOO_LONG, 0, 0},
            '{-1, "dir/",      0, -1, 0, 0, 1, STATUS_TRAILING, 0, 0},
            '{-1, "/",         0, -1, 0, 0, 1, STATUS_TRAILING, 0, 0},
            '{-1, "x/.",       0, -1, 0, 0, 1, STATUS_DOTS,     0, 0},
            '{-1, "..",        0, -1, 1, 0, 1, STATUS_DOTS,     0, 0},
            '{-1, "...",       0, -1, 0, 0, 1, STATUS_OK,       0, 3},
            '{-1, "a/-rf",     0, -1, 0, 0, 1, STATUS_DASH,     0, 0},
            '{-1, "-a b",      0, -1, 0, 0, 1, STATUS_DASH,     0, 0},
            '{-1, "a\tb",      0, -1, 0, 0, 1, STATUS_CONTROL,  0, 0},
            '{-1, "\t/..",     0, -1, 0, 0, 1, STATUS_CONTROL,  0, 0},
            '{-1, "x/",        0,  0, 0, 0, 1, STATUS_CONTROL,  0, 0},
            '{-1, "/\177/ok",  0, -1, 0, 0, 1, STATUS_CONTROL,  0, 0},
            '{-1, "q",         0, 255, 0, 0, 1, STATUS_BAD_CHAR, 0, 0},
            '{-1, "a b",       0, -1, 0, 0, 1, STATUS_BAD_CHAR, 0, 0},
            '{-1, "~",         0, -1, 0, 0, 1, STATUS_BAD_CHAR, 0, 0},
            '{-1, "usr/lib/Az09.-_+@=", 0, -1, 1, 1, 0, 0, 0, 0},
            '{-1, "a/b/c.txt", 0, -1, 0, 1, 0, 0, 0, 0},
            '{ 1, "a",         0, -1, 0, 0, 1, STATUS_OK,       0, 1},
            '{-1, "ab",        0, -1, 0, 0, 1, STATUS_TOO_LONG, 0, 0},
            '{-1, "..",        0, -1, 0, 0, 1, STATUS_DOTS,     0, 0},
            '{ 0, "a",         0, -1, 0, 0, 1, STATUS_TOO_LONG, 0, 0},
            '{-1, "/",         0, -1, 0, 0, 1, STATUS_TRAILING, 0, 0}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].cfg >= 0) write_limit(8'(plan[i].cfg));
            path_q.delete();
            repeat (plan[i].pad) add_word('{FILL_BYTE, 1'b1, 1'b0});
            for (int j = 0; j < plan[i].txt.len(); j++)
                add_word('{plan[i].txt[j], 1'b1, 1'b0});
            if (plan[i].tail >= 0) add_word('{8'(plan[i].tail), 1'b1, 1'b0});
            if (plan[i].noise && path_q.size() > 0)
                path_q.insert(1, '{8'hA5, 1'b0, 1'b0});
            if (plan[i].bare_end) add_word('{8'h5A, 1'b0, 1'b1});
            else path_q[path_q.size() - 1].eon = 1'b1;
            row_v = '{3'(plan[i].status), OFFSET_W'(plan[i].offset), 8'(plan[i].length)};
            quiet = (plan[i].pad > 1000) || ($urandom_range(0, 3) == 0);
            send_path(plan[i].typed, row_v);
        end

        path_items = 0;
        paths      = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       lim = $urandom_range(3, 12);
                1:       lim = 255;
                2:       lim = $urandom_range(0, 3);
                default: lim = $urandom_range(0, 255);
            endcase
            write_limit(8'(lim));
            while (path_items < PATH_WORDS * (phase + 1) / 4 || paths < 15 * (phase + 1)) begin
                quiet = ($urandom_range(0, 3) == 0);
                build_random_path();
                send_path(1'b0, '0);
                paths++;
                // hold off now and then until the result side is empty
                if ((phase == 2 && paths == 31) || $urandom_range(0, 19) == 0) settle();
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
